>>> src/prl_pkg.sv
// prl_pkg: types, character codes and value conversion functions for the
// pitch/roll line parser. No dependencies.
`default_nettype none
package prl_pkg;

  localparam int FRAC_DIGITS = 2;
  localparam int VALUE_WIDTH = 24;
  localparam int FRAC_W      = $clog2(FRAC_DIGITS + 2);
  localparam int EXT_W       = VALUE_WIDTH + 4;

  localparam longint ABSENT_MAG = (64'd99999 * (64'd10 ** FRAC_DIGITS)) / 64'd100;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [VALUE_WIDTH-1:0]        mag_t;
  typedef logic [EXT_W-1:0]              ext_t;

  localparam mag_t MAG_CAP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam mag_t MAG_MAX = MAG_CAP - 1'b1;
  localparam val_t ABSENT  = VALUE_WIDTH'(-ABSENT_MAG);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [2:0] TOKENS_MIN = 3'd4;

  typedef enum logic [1:0] {
    EOL_NONE = 2'd0,
    EOL_LF   = 2'd1,
    EOL_CR   = 2'd2
  } eol_e;

  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_ROLL  = 2'd1,
    KEY_PITCH = 2'd2
  } key_e;

  typedef struct packed {
    logic started;
    logic neg;
    logic frac;
    logic stop;
  } num_flags_t;

  typedef struct packed {
    mag_t              acc;
    num_flags_t        flags;
    logic [FRAC_W-1:0] frac;
  } num_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] scan_line;
  } in_word_t;

  typedef struct packed {
    logic [31:0] start_scan_line;
    val_t        pitch_centi;
    val_t        roll_centi;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } core_res_t;

  // one character of a value token
  function automatic num_t value_step(num_t n, logic [7:0] c);
    num_t r;
    ext_t prod;
    logic go;
    r  = n;
    go = 1'b1;
    prod = '0;
    if (n.flags.stop) begin
      go = 1'b0;
    end else if (!n.flags.started) begin
      if (c == CH_VT || c == CH_FF) begin
        go = 1'b0;
      end else begin
        r.flags.started = 1'b1;
        if (c == CH_MINUS) begin
          r.flags.neg = 1'b1;
          go = 1'b0;
        end else if (c == CH_PLUS) begin
          go = 1'b0;
        end
      end
    end
    if (go) begin
      if (c >= CH_0 && c <= CH_9) begin
        if (!(n.flags.frac && n.frac >= FRAC_W'(FRAC_DIGITS))) begin
          if (n.flags.frac) begin
            r.frac = n.frac + 1'b1;
          end
          prod = EXT_W'(n.acc) * EXT_W'(10) + EXT_W'(c - CH_0);
          r.acc = (prod > EXT_W'(MAG_CAP)) ? MAG_CAP : prod[VALUE_WIDTH-1:0];
        end
      end else if (c == CH_DOT && !n.flags.frac) begin
        r.flags.frac = 1'b1;
      end else begin
        r.flags.stop = 1'b1;
      end
    end
    return r;
  endfunction

  // scale to fixed point and saturate
  function automatic val_t value_finish(num_t n);
    ext_t m;
    val_t r;
    m = EXT_W'(n.acc);
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      if (n.frac <= FRAC_W'(i)) begin
        m = m * EXT_W'(10);
        if (m > EXT_W'(MAG_CAP)) begin
          m = EXT_W'(MAG_CAP);
        end
      end
    end
    if (n.flags.neg) begin
      if (m >= EXT_W'(MAG_CAP)) begin
        r = val_t'(MAG_CAP);
      end else begin
        r = val_t'(~m[VALUE_WIDTH-1:0] + 1'b1);
      end
    end else begin
      if (m >= EXT_W'(MAG_CAP)) begin
        r = val_t'(MAG_MAX);
      end else begin
        r = val_t'(m[VALUE_WIDTH-1:0]);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/prl_input_stage.sv
// prl_input_stage: input word register of the line parser.
// Depends on prl_pkg.
`default_nettype none
module prl_input_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire prl_pkg::in_word_t in_word_i,
  input  wire logic              advance_i,
  output logic                   valid_o,
  output prl_pkg::in_word_t      word_o
);
  import prl_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     accept;

  assign in_stall_o = valid_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign valid_d    = accept | (valid_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule
`default_nettype wire

>>> src/prl_line_core.sv
// prl_line_core: line assembly, tokenizer and name/value state, one byte per
// enabled cycle. Depends on prl_pkg.
`default_nettype none
module prl_line_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire prl_pkg::in_word_t word_i,
  output prl_pkg::core_res_t     res_o
);
  import prl_pkg::*;

  eol_e        eol_q, eol_d;
  logic        has_q, has_d;
  logic [31:0] start_q, start_d;
  logic [2:0]  tcnt_q, tcnt_d;
  logic        intok_q, intok_d;
  logic        isval_q, isval_d;
  logic [1:0]  nlen_q, nlen_d;
  logic [7:0]  nfirst_q, nfirst_d;
  key_e        key_q, key_d;
  num_t        num_q, num_d;
  val_t        pitch_q, pitch_d;
  val_t        roll_q, roll_d;

  logic [7:0]  c;
  logic        is_eol, swallow;
  eol_e        kind;
  val_t        fin;
  logic [7:0]  up;
  key_e        e_key, l_key;
  val_t        e_pitch, e_roll, l_pitch, l_roll;
  logic        e_isval, l_isval;
  logic [2:0]  e_tcnt, l_tcnt;

  assign c = word_i.data_byte;

  always_comb begin
    eol_d = eol_q; has_d = has_q; start_d = start_q; tcnt_d = tcnt_q;
    intok_d = intok_q; isval_d = isval_q; nlen_d = nlen_q; nfirst_d = nfirst_q;
    key_d = key_q; num_d = num_q; pitch_d = pitch_q; roll_d = roll_q;
    res_o = '0;

    fin = value_finish(num_q);

    // state as it stands once the open token is closed
    e_key = KEY_NONE; e_pitch = pitch_q; e_roll = roll_q;
    up = nfirst_q;
    if (up >= CH_LA && up <= CH_LZ) begin
      up = up - CASE_OFS;
    end
    if (isval_q) begin
      if (key_q == KEY_ROLL) begin
        e_roll = fin;
      end else if (key_q == KEY_PITCH) begin
        e_pitch = fin;
      end
    end else if (nlen_q == 2'd1) begin
      if (up == CH_R) begin
        e_key = KEY_ROLL;
      end else if (up == CH_P) begin
        e_key = KEY_PITCH;
      end
    end
    e_isval = ~isval_q;
    e_tcnt  = (tcnt_q < TOKENS_MIN) ? tcnt_q + 3'd1 : tcnt_q;

    l_key = key_q; l_pitch = pitch_q; l_roll = roll_q;
    l_isval = isval_q; l_tcnt = tcnt_q;
    if (intok_q) begin
      l_key = e_key; l_pitch = e_pitch; l_roll = e_roll;
      l_isval = e_isval; l_tcnt = e_tcnt;
    end
    if (l_isval) begin
      if (l_key == KEY_ROLL) begin
        l_roll = '0;
      end else if (l_key == KEY_PITCH) begin
        l_pitch = '0;
      end
    end

    is_eol  = (c == CH_LF) || (c == CH_CR);
    kind    = (c == CH_LF) ? EOL_LF : EOL_CR;
    swallow = (eol_q == EOL_LF && kind == EOL_CR) || (eol_q == EOL_CR && kind == EOL_LF);

    if (is_eol) begin
      eol_d = kind;
      if (!swallow) begin
        if (has_q && l_tcnt >= TOKENS_MIN) begin
          res_o.valid                = 1'b1;
          res_o.word.start_scan_line = start_q;
          res_o.word.pitch_centi     = l_pitch;
          res_o.word.roll_centi      = l_roll;
        end
        intok_d = 1'b0; nlen_d = '0; nfirst_d = '0; num_d = '0;
        has_d = 1'b0; tcnt_d = '0; isval_d = 1'b0; key_d = KEY_NONE;
        pitch_d = ABSENT; roll_d = ABSENT;
        start_d = word_i.scan_line;
      end
    end else begin
      eol_d = EOL_NONE;
      if (!has_q) begin
        start_d = word_i.scan_line;
        has_d   = 1'b1;
      end
      if (c == CH_SP || c == CH_TAB) begin
        if (intok_q) begin
          key_d = e_key; pitch_d = e_pitch; roll_d = e_roll;
          isval_d = e_isval; tcnt_d = e_tcnt;
          intok_d = 1'b0; nlen_d = '0; nfirst_d = '0; num_d = '0;
        end
      end else begin
        intok_d = 1'b1;
        if (!isval_q) begin
          if (nlen_q == 2'd0) begin
            nfirst_d = c;
          end
          if (nlen_q < 2'd2) begin
            nlen_d = nlen_q + 2'd1;
          end
        end else begin
          num_d = value_step(num_q, c);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eol_q <= EOL_NONE; has_q <= 1'b0; start_q <= '0; tcnt_q <= '0;
      intok_q <= 1'b0; isval_q <= 1'b0; nlen_q <= '0; nfirst_q <= '0;
      key_q <= KEY_NONE; num_q <= '0; pitch_q <= ABSENT; roll_q <= ABSENT;
    end else if (en_i) begin
      eol_q <= eol_d; has_q <= has_d; start_q <= start_d; tcnt_q <= tcnt_d;
      intok_q <= intok_d; isval_q <= isval_d; nlen_q <= nlen_d; nfirst_q <= nfirst_d;
      key_q <= key_d; num_q <= num_d; pitch_q <= pitch_d; roll_q <= roll_d;
    end
  end

endmodule
`default_nettype wire

>>> src/pitch_roll_line_parser.sv
// pitch_roll_line_parser: top level, input register, parser core, result register.
// Depends on prl_pkg, prl_input_stage, prl_line_core.
//
//   channel | valid      | stall       | word
//   --------+------------+-------------+---------------------------------------
//   in      | in_valid_i | in_stall_o  | in_word_i  (data_byte, scan_line)
//   out     | out_valid_o| out_stall_i | out_word_o (start_scan_line, pitch, roll)
//
// One byte per cycle unless stalled; out_valid_o is registered from the EOL byte.
// The parser state advances once per byte as it leaves the input register.
// Reset clears all parser state; pitch and roll start at the absent value.
// A stalled result blocks the input register, which then stalls the input.
`default_nettype none
module pitch_roll_line_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire prl_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output prl_pkg::out_word_t      out_word_o
);
  import prl_pkg::*;

  logic      s1_valid;
  in_word_t  s1_word;
  logic      adv;
  core_res_t res;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;

  assign adv = s1_valid & (~out_valid_q | ~out_stall_i);

  prl_input_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .advance_i  (adv),
    .valid_o    (s1_valid),
    .word_o     (s1_word)
  );

  prl_line_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .word_i (s1_word),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (adv) begin
      out_valid_d = res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_word_q <= res.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid)
    else $error("input stalled with empty input register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !adv)
    else $error("pending result word overwritten");

  a_result_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res.valid) |=> out_valid_q)
    else $error("result word lost");

  a_result_on_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && res.valid) |-> (s1_word.data_byte == CH_LF || s1_word.data_byte == CH_CR))
    else $error("result word without line end");

endmodule
`default_nettype wire
